@@ src/lrd_pkg.sv @@
// ----------------------------------------------------------------------------
// lrd_pkg
// shared types, constants and codes for the run-length run decoder
// ----------------------------------------------------------------------------
package lrd_pkg;

	// image geometry
	localparam int IMAGE_WIDTH  = 100;
	localparam int IMAGE_HEIGHT = 17;
	localparam int IMG_TOTAL    = IMAGE_WIDTH * IMAGE_HEIGHT;

	// pixel counter and sum widths
	localparam int PW_W  = $clog2(IMG_TOTAL + 1);
	localparam int LEN_W = 10;
	localparam int SUM_W = ((PW_W > LEN_W) ? PW_W : LEN_W) + 1;

	// result field widths
	localparam int START_W  = 11;
	localparam int GRAY_W   = 8;
	localparam int STATUS_W = 3;
	localparam int LEVEL_W  = 4;

	// record header bits
	localparam logic [7:0]  SHORT_MARK = 8'h01;
	localparam logic [15:0] LONG_BAD   = 16'h0002;

	// status codes
	localparam logic [STATUS_W-1:0] ST_RUN    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADREC = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADLEN = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TOTAL  = 3'd5;

	// command kinds from front to back
	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_RUN    = 2'd1;
	localparam logic [1:0] CMD_BADREC = 2'd2;
	localparam logic [1:0] CMD_TRUNC  = 2'd3;

	// queue depths
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 4;

	typedef struct packed {
		logic [1:0]         kind;
		logic [LEN_W-1:0]   len;
		logic [LEVEL_W-1:0] level;
		logic               eod;
	} cmd_t;

	typedef struct packed {
		logic [START_W-1:0]  run_start;
		logic [LEN_W-1:0]    run_length;
		logic [GRAY_W-1:0]   gray;
		logic [STATUS_W-1:0] status;
		logic                last_of_item;
	} res_t;

	// results written by the back end in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} res_wr_t;

endpackage

@@ src/lrd_front.sv @@
// ----------------------------------------------------------------------------
// lrd_front
// pairs stream bytes into records and classifies them into commands
// ----------------------------------------------------------------------------
module lrd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_data,
	output lrd_pkg::cmd_t     cmd
);

	logic [7:0]  pend_byte_q;
	logic        pend_valid_q;
	logic [15:0] word;

	assign word = {data_byte, pend_byte_q};

	always_comb begin
		cmd.eod   = end_of_data;
		cmd.kind  = lrd_pkg::CMD_NONE;
		cmd.len   = '0;
		cmd.level = '0;
		if (pend_valid_q) begin
			if ((word & lrd_pkg::LONG_BAD) != 16'h0000) begin
				cmd.kind = lrd_pkg::CMD_BADREC;
			end else begin
				cmd.kind  = lrd_pkg::CMD_RUN;
				cmd.len   = word[11:2];
				cmd.level = word[15:12];
			end
		end else if ((data_byte & lrd_pkg::SHORT_MARK) != 8'h00) begin
			cmd.kind  = lrd_pkg::CMD_RUN;
			cmd.len   = lrd_pkg::LEN_W'(data_byte[3:1]);
			cmd.level = data_byte[7:4];
		end else if (end_of_data) begin
			cmd.kind = lrd_pkg::CMD_TRUNC;
		end
	end

	// low byte of a two-byte record waits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_byte_q  <= '0;
		end else if (accept) begin
			if (end_of_data || pend_valid_q) begin
				pend_valid_q <= 1'b0;
			end else if ((data_byte & lrd_pkg::SHORT_MARK) == 8'h00) begin
				pend_valid_q <= 1'b1;
				pend_byte_q  <= data_byte;
			end
		end
	end

endmodule

@@ src/lrd_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// lrd_cmd_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module lrd_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lrd_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output lrd_pkg::cmd_t rd_data
);

	localparam int PTR_W = $clog2(lrd_pkg::CMDQ_DEPTH);

	lrd_pkg::cmd_t    mem [lrd_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;

	assign full     = (cnt_q == (PTR_W + 1)'(lrd_pkg::CMDQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W + 1)'(wr_en) - (PTR_W + 1)'(rd_en);
		end
	end

endmodule

@@ src/lrd_back.sv @@
// ----------------------------------------------------------------------------
// lrd_back
// pixel counter, error tracking and result generation
// ----------------------------------------------------------------------------
module lrd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  lrd_pkg::cmd_t   cmd,
	output lrd_pkg::res_wr_t wr
);

	localparam logic [lrd_pkg::PW_W-1:0]  TOTAL_PW  = lrd_pkg::PW_W'(lrd_pkg::IMG_TOTAL);
	localparam logic [lrd_pkg::SUM_W-1:0] TOTAL_SUM = lrd_pkg::SUM_W'(lrd_pkg::IMG_TOTAL);

	logic [lrd_pkg::PW_W-1:0]  pw_q;
	logic                      halted_q;
	logic [lrd_pkg::PW_W-1:0]  pw_n;
	logic                      halted_n;
	logic [lrd_pkg::SUM_W-1:0] sum;
	logic                      active;
	logic                      err;
	logic                      have_a;
	logic                      have_s;
	lrd_pkg::res_t             ra;
	lrd_pkg::res_t             rs;

	assign active = !halted_q && (pw_q < TOTAL_PW);
	assign sum    = lrd_pkg::SUM_W'(pw_q) + lrd_pkg::SUM_W'(cmd.len);

	always_comb begin
		err      = 1'b0;
		have_a   = 1'b0;
		have_s   = 1'b0;
		pw_n     = pw_q;
		halted_n = halted_q;
		ra       = '0;
		rs       = '0;
		ra.run_start = lrd_pkg::START_W'(pw_q);
		if (active) begin
			case (cmd.kind)
				lrd_pkg::CMD_BADREC: begin
					have_a    = 1'b1;
					err       = 1'b1;
					ra.status = lrd_pkg::ST_BADREC;
				end
				lrd_pkg::CMD_TRUNC: begin
					have_a    = 1'b1;
					err       = 1'b1;
					ra.status = lrd_pkg::ST_TRUNC;
				end
				lrd_pkg::CMD_RUN: begin
					have_a = 1'b1;
					if (cmd.len == '0 || sum > TOTAL_SUM) begin
						err       = 1'b1;
						ra.status = lrd_pkg::ST_BADLEN;
					end else begin
						ra.status     = lrd_pkg::ST_RUN;
						ra.run_length = cmd.len;
						ra.gray       = {cmd.level, 4'h0};
						pw_n          = lrd_pkg::PW_W'(sum);
					end
				end
				default: begin
				end
			endcase
		end
		if (err) begin
			halted_n = 1'b1;
		end
		rs.run_start    = lrd_pkg::START_W'(pw_n);
		rs.status       = (pw_n == TOTAL_PW) ? lrd_pkg::ST_OK : lrd_pkg::ST_TOTAL;
		rs.last_of_item = 1'b1;
		if (cmd.eod) begin
			have_s   = !err && !halted_q;
			pw_n     = '0;
			halted_n = 1'b0;
		end
		ra.last_of_item = !have_s;

		wr    = '0;
		if (fire) begin
			wr.cnt = {1'b0, have_a} + {1'b0, have_s};
		end
		wr.r0 = have_a ? ra : rs;
		wr.r1 = rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q     <= '0;
			halted_q <= 1'b0;
		end else if (fire) begin
			pw_q     <= pw_n;
			halted_q <= halted_n;
		end
	end

endmodule

@@ src/lrd_res_queue.sv @@
// ----------------------------------------------------------------------------
// lrd_res_queue
// four-entry result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module lrd_res_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  lrd_pkg::res_wr_t wr,
	output logic             room,
	input  logic             rd_en,
	output logic             empty,
	output lrd_pkg::res_t    rd_data
);

	localparam int PTR_W = $clog2(lrd_pkg::RESQ_DEPTH);

	lrd_pkg::res_t    mem [lrd_pkg::RESQ_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;
	logic [PTR_W-1:0] wp1;

	assign wp1     = wp_q + 1'b1;
	assign empty   = (cnt_q == '0);
	assign room    = (cnt_q <= (PTR_W + 1)'(lrd_pkg::RESQ_DEPTH - 2));
	assign rd_data = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0) begin
			mem[wp_q] <= wr.r0;
		end
		if (wr.cnt == 2'd2) begin
			mem[wp1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + PTR_W'(wr.cnt);
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W + 1)'(wr.cnt) - (PTR_W + 1)'(rd_en);
		end
	end

endmodule

@@ src/logo_rle_run_decoder_top.sv @@
// ----------------------------------------------------------------------------
// logo_rle_run_decoder_top
// run-length decoder for a 4-bit gray stream, emits runs and a final status
// ----------------------------------------------------------------------------
//
// channel   direction  handshake         payload
// input     in         push / full       data_byte, end_of_data
// result    out        pop / empty       run_start, run_length, gray, status,
//                                        last_of_item
//
// one item per cycle sustained while the result queue has room: the front
// classifies a byte in the cycle it is taken, the back retires one command
// per cycle into the result queue; an item yielding two results (last run
// plus status) costs two result pops; the result drain sets the rate then
// full rises when the two-entry command queue is occupied, which happens only
// while the result queue has fewer than two free entries
// reset clears the pairing state, the pixel counter, the error flag and both
// queues; no clearing pass
// ----------------------------------------------------------------------------
module logo_rle_run_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// input side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic [10:0] run_start,
	output logic [9:0]  run_length,
	output logic [7:0]  gray,
	output logic [2:0]  status,
	output logic        last_of_item
);

	logic             in_acc;      // item taken this cycle
	lrd_pkg::cmd_t    cmd_in;      // classified item from the front
	lrd_pkg::cmd_t    cmd_out;     // oldest command for the back
	logic             cmd_valid;
	logic             res_room;    // result queue can take two results
	logic             back_fire;   // back retires a command
	lrd_pkg::res_wr_t res_wr;
	lrd_pkg::res_t    res_head;
	logic             out_acc;

	assign in_acc    = push && !full;
	assign out_acc   = pop && !empty;
	assign back_fire = cmd_valid && res_room;

	// front: byte pairing and record classification
	lrd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_acc),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.cmd         (cmd_in)
	);

	// decoupling queue between front and back
	lrd_cmd_queue u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc),
		.wr_data  (cmd_in),
		.full     (full),
		.rd_en    (back_fire),
		.rd_valid (cmd_valid),
		.rd_data  (cmd_out)
	);

	// back: pixel count, range checks, run and status results
	lrd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (back_fire),
		.cmd    (cmd_out),
		.wr     (res_wr)
	);

	// result queue, also parts the output handshake from the back
	lrd_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_wr),
		.room    (res_room),
		.rd_en   (out_acc),
		.empty   (empty),
		.rd_data (res_head)
	);

	assign run_start    = res_head.run_start;
	assign run_length   = res_head.run_length;
	assign gray         = res_head.gray;
	assign status       = res_head.status;
	assign last_of_item = res_head.last_of_item;

`ifndef NO_ASSERTIONS
	// a status result always closes the results of its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != lrd_pkg::ST_RUN) |-> last_of_item)
		else $error("status result without last_of_item");

	// runs that reach the output are never empty
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == lrd_pkg::ST_RUN) |-> (run_length != '0))
		else $error("run of zero length emitted");

	// the back never writes results without room for two of them
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr.cnt != 2'd0) |-> res_room)
		else $error("result queue overrun");

	// gray is always a level shifted by four
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (gray[3:0] == 4'h0))
		else $error("gray low nibble not zero");
`endif

endmodule

@@ tb/sv/logo_rle_run_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// logo_rle_run_decoder_top_test
// self-checking bench for the run-length run decoder
// ----------------------------------------------------------------------------
// feeds compressed byte streams through the push/full side and pops results
// from the empty/pop side. a local decoder works out the runs and status codes
// each accepted byte should produce. every popped result is checked field by
// field against the oldest one still due. directed images and error streams
// come first, then random streams with and without sender and receiver idling.
// ----------------------------------------------------------------------------
module logo_rle_run_decoder_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 1000;  // cycles with no handshake on either side
	localparam int HOLD_OFF   = 8;     // settle time once nothing is due

	// kinds of random stream
	typedef enum int {
		FULL_IMAGE,
		SHORT_TOTAL,
		BAD_RECORD,
		ZERO_LENGTH,
		OVERFLOW,
		TRUNCATED,
		NOISE
	} stream_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_data = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [10:0] run_start;
	logic [9:0]  run_length;
	logic [7:0]  gray;
	logic [2:0]  status;
	logic        last_of_item;

	// local decoder state
	logic [10:0] px_count = '0;
	logic [7:0]  low_byte = '0;
	bit          low_held = 1'b0;
	bit          stream_halted = 1'b0;

	// results still due, oldest first
	lrd_pkg::res_t due_runs [$];

	// idling knobs
	int gap_max = 0;      // sender: longest gap after a burst, 0 for none
	int burst_left = 0;
	int stall_pct = 0;    // receiver: chance of starting a stall each cycle
	int stall_max = 0;
	int stall_left = 0;

	// bookkeeping
	int room_left;
	int items_sent = 0;
	int ignored_items = 0;
	int streams_sent = 0;
	int runs_checked = 0;
	int statuses_checked = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	logo_rle_run_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_data  (end_of_data),
		.empty        (empty),
		.pop          (pop),
		.run_start    (run_start),
		.run_length   (run_length),
		.gray         (gray),
		.status       (status),
		.last_of_item (last_of_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// run decoder prediction
	// ------------------------------------------------------------------------

	function automatic lrd_pkg::res_t make_res(input logic [10:0] start,
			input logic [9:0] len, input logic [7:0] g, input logic [2:0] st);
		lrd_pkg::res_t r;
		r.run_start    = start;
		r.run_length   = len;
		r.gray         = g;
		r.status       = st;
		r.last_of_item = 1'b0;
		return r;
	endfunction

	// one accepted byte in, zero to two results queued as due
	function automatic void decode_byte(input logic [7:0] b, input logic eod);
		lrd_pkg::res_t out [2];
		lrd_pkg::res_t r;
		int            n;
		int            len;
		logic [3:0]    level;
		logic [15:0]   word;
		bit            have;
		bit            err;
		n = 0;
		len = 0;
		level = '0;
		have = 1'b0;
		err = 1'b0;
		// halted streams and a full image swallow bytes
		if (!stream_halted && int'(px_count) < lrd_pkg::IMG_TOTAL) begin
			if (low_held) begin
				// second byte of a long record, little endian
				word = {b, low_byte};
				low_held = 1'b0;
				low_byte = '0;
				if ((word & lrd_pkg::LONG_BAD) != '0) begin
					out[n] = make_res(px_count, '0, '0, lrd_pkg::ST_BADREC);
					n++;
					err = 1'b1;
				end else begin
					len = int'(word[11:2]);
					level = word[15:12];
					have = 1'b1;
				end
			end else if ((b & lrd_pkg::SHORT_MARK) != '0) begin
				len = int'(b[3:1]);
				level = b[7:4];
				have = 1'b1;
			end else if (eod) begin
				// stream ends on the low half of a long record
				out[n] = make_res(px_count, '0, '0, lrd_pkg::ST_TRUNC);
				n++;
				err = 1'b1;
			end else begin
				low_byte = b;
				low_held = 1'b1;
			end
			if (have) begin
				if (len == 0 || int'(px_count) + len > lrd_pkg::IMG_TOTAL) begin
					out[n] = make_res(px_count, '0, '0, lrd_pkg::ST_BADLEN);
					n++;
					err = 1'b1;
				end else begin
					out[n] = make_res(px_count, len[9:0], {level, 4'h0}, lrd_pkg::ST_RUN);
					n++;
					px_count = px_count + len[10:0];
				end
			end
			if (err)
				stream_halted = 1'b1;
		end
		if (eod) begin
			// closing status unless an error was already reported
			if (!err && !stream_halted) begin
				out[n] = make_res(px_count, '0, '0,
					(int'(px_count) == lrd_pkg::IMG_TOTAL) ? lrd_pkg::ST_OK
						: lrd_pkg::ST_TOTAL);
				n++;
			end
			px_count = '0;
			low_byte = '0;
			low_held = 1'b0;
			stream_halted = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			r = out[i];
			r.last_of_item = (i == n - 1);
			due_runs.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------

	// drive one byte, hold it until taken, then maybe gap between bursts
	task automatic send_byte(input logic [7:0] b, input logic eod);
		int gap;
		push <= 1'b1;
		data_byte <= b;
		end_of_data <= eod;
		@(posedge clk);
		while (full)
			@(posedge clk);
		decode_byte(b, eod);
		items_sent++;
		if (gap_max > 0) begin
			if (burst_left > 0)
				burst_left--;
			else begin
				burst_left = $urandom_range(0, 15);
				gap = $urandom_range(1, gap_max);
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_short(input int len, input int level, input bit eod);
		logic [2:0] l;
		logic [3:0] v;
		l = 3'(len);
		v = 4'(level);
		send_byte({v, l, 1'b1}, eod);
	endtask

	task automatic send_long(input int len, input int level, input bit eod);
		logic [9:0]  l;
		logic [3:0]  v;
		logic [15:0] word;
		l = 10'(len);
		v = 4'(level);
		word = {v, l, 2'b00};
		send_byte(word[7:0], 1'b0);
		send_byte(word[15:8], eod);
	endtask

	// short form at random when the length fits, otherwise long
	task automatic send_record(input int len, input int level, input bit eod);
		if (len <= 7 && $urandom_range(0, 1) == 1)
			send_short(len, level, eod);
		else
			send_long(len, level, eod);
	endtask

	// run lengths lean small so images take many records
	function automatic int pick_len(input int max_len);
		int roll;
		roll = $urandom_range(0, 3);
		if (max_len <= 7 || roll < 2)
			return $urandom_range(1, (max_len < 7) ? max_len : 7);
		else if (roll == 2)
			return $urandom_range(1, (max_len < 100) ? max_len : 100);
		else
			return $urandom_range(1, (max_len < 1023) ? max_len : 1023);
	endfunction

	// good records that leave at least one pixel free
	task automatic send_good_records(input int count);
		int len;
		for (int i = 0; i < count && room_left > 1; i++) begin
			len = pick_len(room_left - 1);
			room_left -= len;
			send_record(len, $urandom_range(0, 15), 1'b0);
		end
	endtask

	// bytes the block should drop, closed by the end marker
	task automatic send_tail();
		int n;
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
			ignored_items++;
		end
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		ignored_items++;
	endtask

	task automatic send_stream(input stream_kind_t kind);
		int         len;
		int         upper;
		int         n;
		bit         close_now;
		logic [7:0] b;
		room_left = lrd_pkg::IMG_TOTAL;
		streams_sent++;
		close_now = ($urandom_range(0, 3) == 0);
		case (kind)
			FULL_IMAGE: begin
				while (room_left > 0) begin
					len = pick_len(room_left);
					room_left -= len;
					send_record(len, $urandom_range(0, 15), room_left == 0 && !close_now);
				end
				// sometimes trailing bytes past the full image
				if (close_now)
					send_tail();
			end
			SHORT_TOTAL: begin
				send_good_records($urandom_range(0, 8));
				send_record(pick_len(room_left), $urandom_range(0, 15), 1'b1);
			end
			BAD_RECORD: begin
				send_good_records($urandom_range(0, 6));
				b = 8'($urandom_range(0, 255));
				b[1:0] = 2'b10;
				send_byte(b, 1'b0);
				send_byte(8'($urandom_range(0, 255)), close_now);
				if (!close_now)
					send_tail();
			end
			ZERO_LENGTH: begin
				send_good_records($urandom_range(0, 6));
				send_record(0, $urandom_range(0, 15), close_now);
				if (!close_now)
					send_tail();
			end
			OVERFLOW: begin
				send_good_records($urandom_range(0, 6));
				// get below one long run of room, then overshoot
				while (room_left >= 1023) begin
					upper = (room_left - 1 < 1023) ? room_left - 1 : 1023;
					len = $urandom_range(room_left - 1022, upper);
					room_left -= len;
					send_long(len, $urandom_range(0, 15), 1'b0);
				end
				send_long($urandom_range(room_left + 1, 1023), $urandom_range(0, 15), close_now);
				if (!close_now)
					send_tail();
			end
			TRUNCATED: begin
				send_good_records($urandom_range(0, 6));
				b = 8'($urandom_range(0, 255));
				b[0] = 1'b0;
				send_byte(b, 1'b1);
			end
			default: begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom_range(0, 255)), i == n - 1);
			end
		endcase
	endtask

	function automatic stream_kind_t pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)      return FULL_IMAGE;
		else if (roll < 58) return SHORT_TOTAL;
		else if (roll < 67) return BAD_RECORD;
		else if (roll < 76) return ZERO_LENGTH;
		else if (roll < 85) return OVERFLOW;
		else if (roll < 93) return TRUNCATED;
		else                return NOISE;
	endfunction

	// stop sending and let every due result come out
	task automatic wait_for_results();
		push <= 1'b0;
		while (due_runs.size() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic set_idling(input int gap, input int pct, input int longest);
		gap_max = gap;
		burst_left = 0;
		stall_pct = pct;
		stall_max = longest;
	endtask

	// random streams until the budget of counted items is spent
	task automatic run_streams(input int budget);
		int target;
		target = items_sent - ignored_items + budget;
		while (items_sent - ignored_items < target) begin
			send_stream(pick_kind());
			// occasional full drain between streams
			if ($urandom_range(0, 9) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// exact fill with extreme lengths and levels, bytes past the full image
	task automatic test_good_images();
		set_idling(0, 0, 0);
		send_short(7, 15, 1'b0);
		send_long(1023, 15, 1'b0);
		send_long(669, 0, 1'b0);
		send_short(1, 0, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		wait_for_results();
	endtask

	// every error status, mid-stream and on the final byte
	task automatic test_error_statuses();
		set_idling(0, 0, 0);
		// zero length short record, then a silent end marker
		send_short(0, 0, 1'b0);
		send_byte(8'h00, 1'b1);
		// long record with its reserved bit set
		send_byte(8'h56, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b1);
		// end marker on the low half of a long record
		send_byte(8'h00, 1'b1);
		// second long run overshoots the image
		send_long(1023, 15, 1'b0);
		send_long(1023, 15, 1'b0);
		send_byte(8'h11, 1'b1);
		// one pixel then end: wrong total
		send_short(1, 15, 1'b1);
		// errors on the final byte itself
		send_short(0, 0, 1'b1);
		send_byte(8'h02, 1'b0);
		send_byte(8'hff, 1'b1);
		send_long(0, 15, 1'b1);
		wait_for_results();
	endtask

	// random streams with neither side idling, then each side idling alone
	task automatic test_random_streams();
		set_idling(0, 0, 0);
		run_streams(150);
		set_idling(20, 0, 0);
		run_streams(150);
		set_idling(0, 25, 10);
		run_streams(150);
	endtask

	// bursty sender into a receiver with long stalls
	task automatic test_backpressure();
		set_idling(30, 40, 30);
		run_streams(180);
		set_idling(0, 0, 0);
	endtask

	// ------------------------------------------------------------------------
	// result checking and receiver stalls
	// ------------------------------------------------------------------------

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		lrd_pkg::res_t want;
		if (pop && !empty) begin
			if (due_runs.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got start %0d len %0d %s %0d",
					$time, run_start, run_length, "status", status);
				mismatches++;
			end else begin
				want = due_runs.pop_front();
				check_field("run_start", 16'(want.run_start), 16'(run_start));
				check_field("run_length", 16'(want.run_length), 16'(run_length));
				check_field("gray", 16'(want.gray), 16'(gray));
				check_field("status", 16'(want.status), 16'(status));
				check_field("last_of_item", 16'(want.last_of_item), 16'(last_of_item));
				if (want.status == lrd_pkg::ST_RUN)
					runs_checked++;
				else
					statuses_checked++;
			end
		end
		// receiver: stretches of stalls of random length
		if (!arst_n)
			pop <= 1'b0;
		else if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, stall_max);
			pop <= 1'b0;
		end else
			pop <= 1'b1;
	end

	// watchdog: too long with no handshake on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_good_images();
		test_error_statuses();
		test_random_streams();
		test_backpressure();
		wait_for_results();
		$display("covered %0d bytes (%0d dropped by design) in %0d streams",
			items_sent, ignored_items, streams_sent);
		$display("checked %0d runs and %0d status results, %0d mismatches",
			runs_checked, statuses_checked, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
